/* rtl/tlpjq_pkg.sv */
// Types and constants shared by the three level priority job queue.
package tlpjq_pkg;

  localparam int unsigned NumRings   = 3;
  localparam int unsigned MinLog2    = 6;
  localparam int unsigned CfgWidth   = 4;
  localparam int unsigned PendWidth  = 11;
  localparam int unsigned OutHandleW = 32;

  localparam logic [CfgWidth-1:0] CapLog2Reset = 4'd10;

  // opcode values
  localparam logic OpEnqueue = 1'b0;
  localparam logic OpDequeue = 1'b1;

  // ring numbers
  localparam logic [1:0] PrioHigh   = 2'd0;
  localparam logic [1:0] PrioNormal = 2'd1;
  localparam logic [1:0] PrioLow    = 2'd2;

  typedef struct packed {
    logic        opcode;
    logic [1:0]  priority_req;
    logic [31:0] job_handle;
  } cmd_t;

  typedef struct packed {
    logic                  ok;
    logic [OutHandleW-1:0] out_handle;
    logic [1:0]            out_priority;
    logic [PendWidth-1:0]  queued_high;
    logic [PendWidth-1:0]  queued_normal;
    logic [PendWidth-1:0]  queued_low;
  } rsp_t;

endpackage

/* rtl/three_level_priority_job_queue.sv */
// Strict priority job queue: three ring FIFOs of job handles in one memory.
//
// Usage:
//   Command channel: drive cmd_i and pulse start_i. A word is taken at every
//   rising edge where start_i is high and busy_o is low. busy_o stays low, so
//   one enqueue or dequeue word can be issued in every cycle.
//   Result channel: done_o is high for exactly one cycle, the cycle after the
//   command was taken, with rsp_o valid in that cycle. There is no back
//   pressure: the receiver must take the word in that cycle.
//   Throughput is one word per cycle, set by the single ring memory port,
//   which does either the enqueue write or the dequeue read.
//   Config channel: cfg_data_i sets log2 of the usable entries per ring
//   (clamped to 6 .. log2(RING_DEPTH)). cfg_ready_o is always high. Any write
//   empties all three rings. Write only while no result is outstanding.
//   Reset: rings empty, capacity log2 is 10. The ring memory is not cleared;
//   only entries that were enqueued are ever read back.
//   A RING_DEPTH that is not a power of two acts as the largest power of two
//   below it.
module three_level_priority_job_queue
  import tlpjq_pkg::*;
#(
  parameter int unsigned RING_DEPTH   = 1024,
  parameter int unsigned HANDLE_WIDTH = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  output logic                busy_o,
  input  cmd_t                cmd_i,
  output logic                done_o,
  output rsp_t                rsp_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgWidth-1:0] cfg_data_i
);

  // floor of log2(RING_DEPTH)
  localparam int unsigned MaxLog2  = $clog2(RING_DEPTH + 1) - 1;
  localparam int unsigned PtrW     = MaxLog2;
  localparam int unsigned CntW     = PtrW + 1;
  localparam int unsigned AddrW    = PtrW + 2;
  localparam int unsigned MemDepth = NumRings << PtrW;
  localparam int unsigned StoreW  = (HANDLE_WIDTH < OutHandleW) ? HANDLE_WIDTH : OutHandleW;
  localparam int unsigned LogW    = $clog2(MaxLog2 + 1) + 1;

  // ring state
  logic [PtrW-1:0] rd_ptr_q [NumRings];
  logic [PtrW-1:0] rd_ptr_d [NumRings];
  logic [PtrW-1:0] wr_ptr_q [NumRings];
  logic [PtrW-1:0] wr_ptr_d [NumRings];
  logic [CntW-1:0] fill_q   [NumRings];
  logic [CntW-1:0] fill_d   [NumRings];

  logic [CfgWidth-1:0] cap_log2_q;

  // result stage
  logic       done_q;
  logic       ok_q, ok_d;
  logic       deq_q;
  logic [1:0] prio_q, prio_d;

  // memory
  logic [StoreW-1:0] mem [MemDepth];
  logic [StoreW-1:0] rdata_q;
  logic [AddrW-1:0]  mem_addr;
  logic              mem_we, mem_re;

  logic            accept;
  logic            cfg_wr;
  logic [LogW-1:0] eff_log2;
  logic [CntW-1:0] cap;
  logic [PtrW-1:0] ptr_mask;
  logic [1:0]      enq_ring;
  logic            enq_ok;

  assign busy_o      = 1'b0;
  assign cfg_ready_o = 1'b1;
  assign accept      = start_i && !busy_o;
  assign cfg_wr      = cfg_valid_i && cfg_ready_o;

  // clamp capacity log2 into the legal range
  always_comb begin
    priority if (LogW'(cap_log2_q) < LogW'(MinLog2)) begin
      eff_log2 = LogW'(MinLog2);
    end else if (LogW'(cap_log2_q) > LogW'(MaxLog2)) begin
      eff_log2 = LogW'(MaxLog2);
    end else begin
      eff_log2 = LogW'(cap_log2_q);
    end
  end

  assign cap      = CntW'(1) << eff_log2;
  assign ptr_mask = PtrW'(cap - CntW'(1));

  // priority three folds onto the low ring
  assign enq_ring = (cmd_i.priority_req > PrioLow) ? PrioLow : cmd_i.priority_req;
  assign enq_ok   = fill_q[enq_ring] < cap;

  always_comb begin
    for (int r = 0; r < NumRings; r++) begin
      rd_ptr_d[r] = rd_ptr_q[r];
      wr_ptr_d[r] = wr_ptr_q[r];
      fill_d[r]   = fill_q[r];
    end
    ok_d     = 1'b0;
    prio_d   = PrioHigh;
    mem_we   = 1'b0;
    mem_re   = 1'b0;
    mem_addr = {enq_ring, wr_ptr_q[enq_ring] & ptr_mask};
    if (accept) begin
      unique case (cmd_i.opcode)
        OpEnqueue: begin
          if (enq_ok) begin
            mem_we             = 1'b1;
            wr_ptr_d[enq_ring] = (wr_ptr_q[enq_ring] + PtrW'(1)) & ptr_mask;
            fill_d[enq_ring]   = fill_q[enq_ring] + CntW'(1);
            ok_d               = 1'b1;
          end
        end
        OpDequeue: begin
          // highest non-empty ring wins
          priority if (fill_q[PrioHigh] != '0) begin
            prio_d = PrioHigh;
            ok_d   = 1'b1;
          end else if (fill_q[PrioNormal] != '0) begin
            prio_d = PrioNormal;
            ok_d   = 1'b1;
          end else if (fill_q[PrioLow] != '0) begin
            prio_d = PrioLow;
            ok_d   = 1'b1;
          end
          if (ok_d) begin
            mem_re           = 1'b1;
            mem_addr         = {prio_d, rd_ptr_q[prio_d] & ptr_mask};
            rd_ptr_d[prio_d] = (rd_ptr_q[prio_d] + PtrW'(1)) & ptr_mask;
            fill_d[prio_d]   = fill_q[prio_d] - CntW'(1);
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_log2_q <= CapLog2Reset;
      done_q     <= 1'b0;
      ok_q       <= 1'b0;
      deq_q      <= 1'b0;
      prio_q     <= PrioHigh;
      for (int r = 0; r < NumRings; r++) begin
        rd_ptr_q[r] <= '0;
        wr_ptr_q[r] <= '0;
        fill_q[r]   <= '0;
      end
    end else begin
      done_q <= accept;
      if (accept) begin
        ok_q   <= ok_d;
        deq_q  <= (cmd_i.opcode == OpDequeue);
        prio_q <= prio_d;
      end
      if (cfg_wr) begin
        // new capacity empties every ring
        cap_log2_q <= cfg_data_i;
        for (int r = 0; r < NumRings; r++) begin
          rd_ptr_q[r] <= '0;
          wr_ptr_q[r] <= '0;
          fill_q[r]   <= '0;
        end
      end else begin
        for (int r = 0; r < NumRings; r++) begin
          rd_ptr_q[r] <= rd_ptr_d[r];
          wr_ptr_q[r] <= wr_ptr_d[r];
          fill_q[r]   <= fill_d[r];
        end
      end
    end
  end

  // single port ring memory, registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_addr] <= cmd_i.job_handle[StoreW-1:0];
    end
    if (mem_re) begin
      rdata_q <= mem[mem_addr];
    end
  end

  // counts are already post-step during the result cycle
  assign done_o              = done_q;
  assign rsp_o.ok            = ok_q;
  assign rsp_o.out_handle    = (ok_q && deq_q) ? OutHandleW'(rdata_q) : '0;
  assign rsp_o.out_priority  = (ok_q && deq_q) ? prio_q : PrioHigh;
  assign rsp_o.queued_high   = PendWidth'(fill_q[PrioHigh]);
  assign rsp_o.queued_normal = PendWidth'(fill_q[PrioNormal]);
  assign rsp_o.queued_low    = PendWidth'(fill_q[PrioLow]);

  // a ring never holds more than its capacity
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q[PrioHigh] <= cap && fill_q[PrioNormal] <= cap && fill_q[PrioLow] <= cap)
    else $error("ring fill count above capacity");

  // a result only follows an accepted word
  a_done_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(accept))
    else $error("result without command");

  // failed dequeue only when all rings are empty
  a_deq_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && cmd_i.opcode == OpDequeue && !ok_d) |->
      (fill_q[PrioHigh] == '0 && fill_q[PrioNormal] == '0 && fill_q[PrioLow] == '0))
    else $error("dequeue refused while a ring holds entries");

  // accepted enqueue without a config write bumps its ring count by one
  a_enq_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !cfg_wr && cmd_i.opcode == OpEnqueue && enq_ok) |=>
      fill_q[$past(enq_ring)] == $past(fill_q[enq_ring]) + CntW'(1))
    else $error("enqueue did not advance fill count");

endmodule
